// ----- rtl/core/ntcu_pkg.sv -----
// Package: opcodes, stage structs and helpers for the numeric conversion unit.
package ntcu_pkg;

    typedef enum logic [3:0] {
        OP_I2L = 4'd0,  OP_I2F = 4'd1,  OP_I2D = 4'd2,  OP_L2I = 4'd3,
        OP_L2F = 4'd4,  OP_L2D = 4'd5,  OP_F2I = 4'd6,  OP_F2L = 4'd7,
        OP_F2D = 4'd8,  OP_D2I = 4'd9,  OP_D2L = 4'd10, OP_D2F = 4'd11,
        OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14, OP_NONE = 4'd15
    } t_op;

    // Stage 1 -> 2: decoded operand. Integer sources become sign + magnitude,
    // float sources become sign + significand + unbiased exponent.
    typedef struct packed {
        t_op         op;
        logic        sign;
        logic [63:0] mag;       // integer magnitude or significand (hidden bit at 52)
        logic [12:0] exp;       // signed unbiased exponent of significand bit 52
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [63:0] direct;    // result for the trivial ops
    } t_dec;

    // Stage 2 -> 3: normalized value, msb of mag at bit 63.
    typedef struct packed {
        t_op         op;
        logic        sign;
        logic [63:0] mag;
        logic [12:0] exp;       // signed exponent of bit 63
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [51:0] nan_pay;
        logic [63:0] direct;
    } t_norm;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/ntcu_if.sv -----
// Valid/ready channel interface carrying the conversion payloads.
interface ntcu_in_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [63:0] operand_bits;
    modport source (output valid, mode, operand_bits, input ready);
    modport sink (input valid, mode, operand_bits, output ready);
endinterface

interface ntcu_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    modport source (output valid, result_bits, input ready);
    modport sink (input valid, result_bits, output ready);
endinterface

// ----- rtl/core/ntcu_decode.sv -----
// Stage 1 logic: operand unpacking and integer negation.
module ntcu_decode (
    input  logic [3:0]      i_mode,
    input  logic [63:0]     i_operand_bits,
    output ntcu_pkg::t_dec  o_dec
);
    import ntcu_pkg::*;

    logic [31:0] lo;
    logic [63:0] x;

    always_comb begin
        x  = i_operand_bits;
        lo = x[31:0];
        o_dec         = '0;
        o_dec.op      = t_op'(i_mode);
        case (t_op'(i_mode))
            OP_I2F, OP_I2D: begin
                o_dec.sign    = lo[31];
                o_dec.mag     = {32'd0, lo[31] ? (32'd0 - lo) : lo};
                o_dec.is_zero = (lo == 32'd0);
            end
            OP_L2F, OP_L2D: begin
                o_dec.sign    = x[63];
                o_dec.mag     = x[63] ? (64'd0 - x) : x;
                o_dec.is_zero = (x == 64'd0);
            end
            OP_F2I, OP_F2L, OP_F2D: begin
                o_dec.sign    = lo[31];
                o_dec.mag     = {11'd0, (lo[30:23] != 8'd0), lo[22:0], 29'd0};
                o_dec.exp     = (lo[30:23] == 8'd0) ? -13'sd126
                                : 13'({5'd0, lo[30:23]}) - 13'd127;
                o_dec.is_nan  = (lo[30:23] == 8'hFF) && (lo[22:0] != 23'd0);
                o_dec.is_inf  = (lo[30:23] == 8'hFF) && (lo[22:0] == 23'd0);
                o_dec.is_zero = (lo[30:0] == 31'd0);
                o_dec.direct  = {12'd0, lo[22:0], 29'd0}; // NaN payload
            end
            OP_D2I, OP_D2L, OP_D2F: begin
                o_dec.sign    = x[63];
                o_dec.mag     = {11'd0, (x[62:52] != 11'd0), x[51:0]};
                o_dec.exp     = (x[62:52] == 11'd0) ? -13'sd1022
                                : 13'({2'd0, x[62:52]}) - 13'd1023;
                o_dec.is_nan  = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
                o_dec.is_inf  = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
                o_dec.is_zero = (x[62:0] == 63'd0);
                o_dec.direct  = {12'd0, x[51:0]};
            end
            OP_I2L:  o_dec.direct = {{32{lo[31]}}, lo};
            OP_L2I:  o_dec.direct = {32'd0, lo};
            OP_I2B:  o_dec.direct = {32'd0, {24{lo[7]}}, lo[7:0]};
            OP_I2C:  o_dec.direct = {48'd0, lo[15:0]};
            OP_I2S:  o_dec.direct = {32'd0, {16{lo[15]}}, lo[15:0]};
            default: o_dec.direct = '0;
        endcase
    end
endmodule

// ----- rtl/core/ntcu_normalize.sv -----
// Stage 2 logic: leading-zero count and left normalization.
module ntcu_normalize (
    input  ntcu_pkg::t_dec  i_dec,
    output ntcu_pkg::t_norm o_norm
);
    import ntcu_pkg::*;

    logic [6:0] lz;
    logic       is_int;

    always_comb begin
        is_int = (i_dec.op == OP_I2F) || (i_dec.op == OP_I2D)
              || (i_dec.op == OP_L2F) || (i_dec.op == OP_L2D);
        lz = lzc64(i_dec.mag);
        o_norm         = '0;
        o_norm.op      = i_dec.op;
        o_norm.sign    = i_dec.sign;
        o_norm.is_nan  = i_dec.is_nan;
        o_norm.is_inf  = i_dec.is_inf;
        o_norm.is_zero = i_dec.is_zero;
        o_norm.nan_pay = i_dec.direct[51:0];
        o_norm.direct  = i_dec.direct;
        o_norm.mag     = (lz[6]) ? 64'd0 : (i_dec.mag << lz[5:0]);
        // Integers: bit 63 weighs 2^63. Floats: bit 52 weighs 2^exp.
        if (is_int) o_norm.exp = 13'd63 - 13'({6'd0, lz});
        else        o_norm.exp = i_dec.exp + 13'd11 - 13'({6'd0, lz});
    end
endmodule

// ----- rtl/core/ntcu_pack.sv -----
// Stage 3 logic: rounding, saturation and result packing.
module ntcu_pack (
    input  ntcu_pkg::t_norm i_norm,
    output logic [63:0]     o_result_bits
);
    import ntcu_pkg::*;

    logic signed [12:0] e;
    logic [63:0]  m;
    logic [127:0] wide;
    logic [63:0]  mg;
    logic [12:0]  sh;
    logic [63:0]  r;
    logic [63:0]  lim;
    logic         big;
    // single / double rounding
    logic [24:0]  sk;
    logic [53:0]  dk;
    logic         g, st;
    logic [12:0]  ef;
    logic [63:0]  sm;
    logic [7:0]   dsh;

    always_comb begin
        e  = i_norm.exp;
        m  = i_norm.mag;
        r  = '0;
        mg = '0; wide = '0; sh = '0; lim = '0; big = 1'b0;
        sk = '0; dk = '0; g = 1'b0; st = 1'b0; ef = '0; sm = '0; dsh = '0;
        case (i_norm.op)
            OP_F2I, OP_F2L, OP_D2I, OP_D2L: begin
                big = (i_norm.op == OP_F2L) || (i_norm.op == OP_D2L);
                lim = big ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
                if (e < 0 || i_norm.is_zero) mg = '0;
                else if (e > 63)              mg = '1;
                else mg = m >> (6'd63 - 6'(e));
                if (i_norm.is_nan) r = '0;
                else if (i_norm.is_inf || e > 63 || (!i_norm.sign && mg >= lim)
                         || (i_norm.sign && mg > lim))
                    r = i_norm.sign ? lim : lim - 64'd1;
                else r = i_norm.sign ? (64'd0 - mg) : mg;
                if (!big) r = {32'd0, r[31:0]};
            end
            OP_I2D, OP_L2D, OP_F2D: begin
                dk = {1'b0, m[63:11]} + {53'd0, m[10] & ((m[9:0] != 0) | m[11])};
                ef = e + 13'd1023 + {12'd0, dk[53]};
                if (dk[53]) dk = dk >> 1;
                if (i_norm.is_nan)
                    r = {i_norm.sign, 11'h7FF, 1'b1, i_norm.nan_pay[50:0]};
                else if (i_norm.is_inf) r = {i_norm.sign, 11'h7FF, 52'd0};
                else if (i_norm.is_zero) r = {i_norm.sign, 63'd0};
                else r = {i_norm.sign, ef[10:0], dk[51:0]};
            end
            OP_I2F, OP_L2F, OP_D2F: begin
                if (e >= -126) begin
                    sm = m;
                    dsh = 8'd40;
                end else begin
                    // subnormal: shift further right, keeping sticky
                    sh = 13'd40 + 13'(-126) - e;
                    dsh = (sh > 13'd100) ? 8'd100 : sh[7:0];
                    sm = m;
                end
                wide = {sm, 64'd0} >> dsh;
                sk = {1'b0, wide[87:64]};
                g  = wide[63];
                st = (wide[62:0] != 0);
                sk = sk + {24'd0, g & (st | sk[0])};
                if (e >= -126) begin
                    ef = e + 13'd127 + {12'd0, sk[24]};
                    if (sk[24]) sk = sk >> 1;
                end else ef = '0;
                if (i_norm.is_nan)
                    r = {32'd0, i_norm.sign, 8'hFF, 1'b1, i_norm.nan_pay[50:29]};
                else if (i_norm.is_inf) r = {32'd0, i_norm.sign, 8'hFF, 23'd0};
                else if (i_norm.is_zero) r = {32'd0, i_norm.sign, 31'd0};
                else if (e >= -126 && $signed(ef) > 254)
                    r = {32'd0, i_norm.sign, 8'hFF, 23'd0};
                else if (e >= -126) r = {32'd0, i_norm.sign, ef[7:0], sk[22:0]};
                else r = {32'd0, i_norm.sign, 7'd0, sk[23:0]};
                if ((i_norm.op == OP_I2F || i_norm.op == OP_L2F) && i_norm.is_zero)
                    r = '0;
            end
            default: r = i_norm.direct;
        endcase
        if ((i_norm.op == OP_I2D || i_norm.op == OP_L2D) && i_norm.is_zero) r = '0;
        o_result_bits = r;
    end
endmodule

// ----- rtl/core/numeric_type_conversion_unit.sv -----
// Top level: three-stage numeric type conversion pipeline.
//  channel  | dir | payload
//  in_ch    | in  | mode[3:0], operand_bits[63:0]
//  out_ch   | out | result_bits[63:0]
// One item per cycle while out_ch is not stalled; each result passes through the
// decode, normalize and pack stage registers in order before out_ch.valid rises.
// Stages: decode/negate, leading-zero normalize, round/saturate/pack.
// Synchronous active-low reset clears the stage valid bits only.
// An output stall holds every full stage; empty stages still fill, so up to three
// items wait before the input stalls.
module numeric_type_conversion_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ntcu_in_if.sink    in_ch,
    ntcu_out_if.source out_ch
);
    import ntcu_pkg::*;

    t_dec        n_dec, r_dec;
    t_norm       n_norm, r_norm;
    logic [63:0] n_res, r_res;
    logic        r_v1, r_v2, r_v3;
    logic        adv1, adv2, adv3;

    ntcu_decode u_dec (.i_mode(in_ch.mode), .i_operand_bits(in_ch.operand_bits),
                       .o_dec(n_dec));
    ntcu_normalize u_norm (.i_dec(r_dec), .o_norm(n_norm));
    ntcu_pack u_pack (.i_norm(r_norm), .o_result_bits(n_res));

    assign adv3 = !r_v3 || out_ch.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign in_ch.ready = adv1;
    assign out_ch.valid = r_v3;
    assign out_ch.result_bits = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= in_ch.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_dec  <= n_dec;
        if (adv2) r_norm <= n_norm;
        if (adv3) r_res  <= n_res;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !out_ch.ready |=> r_v3 && $stable(r_res)) else $error("result lost");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> r_v1) else $error("item dropped");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && adv3 |=> r_v3) else $error("stage 2 item dropped");
endmodule
